### hw/rtl/rmcp_pkg.sv
// ----------------------------------------------------------------------------
// rmcp_pkg
// Types and constants shared by the paletted converter and its mip chain.
// ----------------------------------------------------------------------------
package rmcp_pkg;

  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MIPS   = 2'd2;

  localparam logic [7:0]  TRANSPARENT_INDEX = 8'd255;
  localparam logic [10:0] RESET_WIDTH       = 11'd256;
  localparam logic [10:0] RESET_HEIGHT      = 11'd256;

  typedef struct packed {
    logic        operation;
    logic [15:0] table_index;
    logic [7:0]  table_value;
    logic [31:0] pixel_rgba;
  } in_t;

  typedef struct packed {
    logic [7:0]  palette_index;
    logic [1:0]  mip_level;
    logic [19:0] position;
    logic        last_of_run;
  } out_t;

  // 5:6:5 key: red 7:3 at 4:0, green 7:2 at 10:5, blue 7:3 at 15:11.
  function automatic logic [15:0] key565(input logic [31:0] rgba);
    key565 = {rgba[23:19], rgba[15:10], rgba[7:3]};
  endfunction

endpackage

### hw/rtl/rmcp_ram.sv
// ----------------------------------------------------------------------------
// rmcp_ram
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rmcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rmcp_ofifo.sv
// ----------------------------------------------------------------------------
// rmcp_ofifo
// Four-entry result queue between the level engine and the output channel.
// ----------------------------------------------------------------------------
module rmcp_ofifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rmcp_pkg::out_t  push_data,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output rmcp_pkg::out_t  out_data
);

  rmcp_pkg::out_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 3'd0);
  assign out_data  = mem[rd_ptr];
  assign room      = (count < 3'd4);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b00, push} - {2'b00, pop};
    end
  end

endmodule

### hw/rtl/rgba_mip_chain_to_paletted_core.sv
// ----------------------------------------------------------------------------
// rgba_mip_chain_to_paletted_core
// RGBA to palette index converter that also builds a box-filtered mip chain.
// ----------------------------------------------------------------------------
// Input items are either colour table writes or pixels in raster order. A
// transfer on the input is taken when in_valid is high and in_stall is low;
// a result transfer happens when out_valid is high and out_stall is low.
// Registers are written over the cfg channel, which is always ready; a write
// to the width, height or mips register restarts the image at row 0, column 0.
// Each result (one per level reached) passes a read phase, which reads the
// colour table and the pair-sum memory of that level, and then a form phase,
// which forms the result, queues it and makes the averaged pixel for the
// next level. A new input item is taken when idle or in the form phase of a
// pixel's last result; a table write does not occupy the engine.
// Results wait in a four-entry queue; while it is full the engine pauses in
// its read phase and in_stall stays high. Reset empties the queue, restores
// the register defaults and clears the counters; colour table contents are
// undefined until written.
// ----------------------------------------------------------------------------
module rgba_mip_chain_to_paletted_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MIP_LEVELS = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rmcp_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rmcp_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [10:0]     cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = YW + WW + 1;
  localparam int D1 = (MAX_WIDTH + 1) / 2;
  localparam int D2 = (MAX_WIDTH + 3) / 4;
  localparam int D3 = (MAX_WIDTH + 7) / 8;
  localparam int A1 = (D1 > 1) ? $clog2(D1) : 1;
  localparam int A2 = (D2 > 1) ? $clog2(D2) : 1;
  localparam int A3 = (D3 > 1) ? $clog2(D3) : 1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_READ = 2'd1;
  localparam logic [1:0] PH_FORM = 2'd2;

  logic [10:0]   width_reg;
  logic [10:0]   height_reg;
  logic          mips_reg;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [XW-1:0] col;
  logic [YW-1:0] row;

  logic [1:0]    phase;
  logic [31:0]   pix;
  logic [1:0]    lvl;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [WW-1:0] lw;
  logic [31:0]   held [3];

  logic [35:0]   pair;
  logic [35:0]   pair_reg;
  logic          cont;
  logic          cont_reg;
  logic          alpha0_reg;
  logic [19:0]   pos_reg;
  logic [PW-1:0] pos_full;
  logic          mip_go;
  logic [XW-1:0] idx;
  logic          idx_ok;
  logic          advance;
  logic          accept;
  logic          room;

  logic [7:0]    tbl_rdata;
  logic [35:0]   s1_rdata;
  logic [35:0]   s2_rdata;
  logic [35:0]   s3_rdata;
  logic [35:0]   sum_rdata;
  logic [31:0]   next_pix;
  logic          s_we1;
  logic          s_we2;
  logic          s_we3;
  rmcp_pkg::out_t result;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (width_reg == 11'd0) eff_w = WW'(1);
    else if (32'(width_reg) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(width_reg);
    if (height_reg == 11'd0) eff_h = HW'(1);
    else if (32'(height_reg) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else eff_h = HW'(height_reg);
  end

  // Decisions for the current level, all known in the read phase.
  always_comb begin
    mip_go = mips_reg && (32'(lvl) < MIP_LEVELS);
    idx    = x >> 1;
    case (lvl)
      2'd0:    idx_ok = (32'(idx) < D1);
      2'd1:    idx_ok = (32'(idx) < D2);
      default: idx_ok = (32'(idx) < D3);
    endcase
    for (int c = 0; c < 4; c++) begin
      pair[c*9 +: 9] = {1'b0, held[lvl][c*8 +: 8]} + {1'b0, pix[c*8 +: 8]};
    end
    cont     = mip_go && x[0] && idx_ok && y[0];
    pos_full = PW'(y) * PW'(lw) + PW'(x);
    advance  = (phase == PH_READ) && room;
    s_we1 = advance && mip_go && x[0] && idx_ok && !y[0] && (lvl == 2'd0);
    s_we2 = advance && mip_go && x[0] && idx_ok && !y[0] && (lvl == 2'd1);
    s_we3 = advance && mip_go && x[0] && idx_ok && !y[0] && (lvl == 2'd2);
  end

  always_comb begin
    case (lvl)
      2'd0:    sum_rdata = s1_rdata;
      2'd1:    sum_rdata = s2_rdata;
      default: sum_rdata = s3_rdata;
    endcase
    for (int c = 0; c < 4; c++) begin
      next_pix[c*8 +: 8] = 8'(({1'b0, sum_rdata[c*9 +: 9]}
                               + {1'b0, pair_reg[c*9 +: 9]}) >> 2);
    end
  end

  assign in_stall = !((phase == PH_IDLE) || ((phase == PH_FORM) && !cont_reg));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    result.palette_index = alpha0_reg ? rmcp_pkg::TRANSPARENT_INDEX : tbl_rdata;
    result.mip_level     = lvl;
    result.position      = pos_reg;
    result.last_of_run   = !cont_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= rmcp_pkg::RESET_WIDTH;
      height_reg <= rmcp_pkg::RESET_HEIGHT;
      mips_reg   <= 1'b1;
      col        <= '0;
      row        <= '0;
      phase      <= PH_IDLE;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rmcp_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
          rmcp_pkg::CFG_HEIGHT: height_reg <= cfg_data;
          rmcp_pkg::CFG_MIPS:   mips_reg   <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index inside {rmcp_pkg::CFG_WIDTH, rmcp_pkg::CFG_HEIGHT,
                              rmcp_pkg::CFG_MIPS}) begin
          col <= '0;
          row <= '0;
        end
      end
      case (phase)
        PH_READ: if (room) phase <= PH_FORM;
        PH_FORM: if (cont_reg) phase <= PH_READ;
                 else phase <= PH_IDLE;
        default: phase <= PH_IDLE;
      endcase
      if (accept && in_data.operation == rmcp_pkg::OP_PIXEL) begin
        phase <= PH_READ;
        if ((WW'(col) + WW'(1)) >= eff_w) begin
          col <= '0;
          if ((HW'(row) + HW'(1)) >= eff_h) row <= '0;
          else row <= row + YW'(1);
        end else begin
          col <= col + XW'(1);
        end
      end
    end
  end

  // Engine payload.
  always_ff @(posedge clk) begin
    if (accept && in_data.operation == rmcp_pkg::OP_PIXEL) begin
      pix <= in_data.pixel_rgba;
      lvl <= 2'd0;
      x   <= col;
      y   <= row;
      lw  <= eff_w;
    end else if (phase == PH_FORM && cont_reg) begin
      pix <= next_pix;
      lvl <= lvl + 2'd1;
      x   <= x >> 1;
      y   <= y >> 1;
      lw  <= lw >> 1;
    end
    if (advance) begin
      pair_reg   <= pair;
      cont_reg   <= cont;
      alpha0_reg <= (pix[31:24] == 8'd0);
      pos_reg    <= 20'(pos_full);
      if (mip_go && !x[0]) held[lvl] <= pix;
    end
  end

  rmcp_ram #(.WIDTH(8), .DEPTH(65536), .AW(16)) u_ctab (
    .clk   (clk),
    .we    (accept && in_data.operation == rmcp_pkg::OP_TABLE),
    .waddr (in_data.table_index),
    .wdata (in_data.table_value),
    .raddr (rmcp_pkg::key565(pix)),
    .rdata (tbl_rdata)
  );

  rmcp_ram #(.WIDTH(36), .DEPTH(D1), .AW(A1)) u_sums1 (
    .clk   (clk),
    .we    (s_we1),
    .waddr (A1'(idx)),
    .wdata (pair),
    .raddr (A1'(idx)),
    .rdata (s1_rdata)
  );

  rmcp_ram #(.WIDTH(36), .DEPTH(D2), .AW(A2)) u_sums2 (
    .clk   (clk),
    .we    (s_we2),
    .waddr (A2'(idx)),
    .wdata (pair),
    .raddr (A2'(idx)),
    .rdata (s2_rdata)
  );

  rmcp_ram #(.WIDTH(36), .DEPTH(D3), .AW(A3)) u_sums3 (
    .clk   (clk),
    .we    (s_we3),
    .waddr (A3'(idx)),
    .wdata (pair),
    .raddr (A3'(idx)),
    .rdata (s3_rdata)
  );

  rmcp_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (phase == PH_FORM),
    .push_data (result),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
